>>> rtl/dvrt_pkg.sv
// Shared constants for the distance-vector route table.
package dvrt_pkg;

    localparam int ADDR_W      = 32;
    localparam int COST_W      = 16;
    localparam int TTL_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] FUNC_ADV     = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_INSTALL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL_RELOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK       = 2'd2;

endpackage

>>> rtl/distance_vector_route_table_unit.sv
// Distance-vector route table: a sequencer over one table memory.
//
// Input channel (in_valid/in_ready) takes one item: an advertised entry, a
// tick or an install. Output channel (out_valid/out_ready) carries dumped
// table entries, valid slots in slot order up to MAX_RESULTS, out_last on the final one.
// Configuration writes go through cfg_we/cfg_index/cfg_data; the user must make them while idle, unenforced.
//
// Every item walks the table memory one slot per cycle, a dump only while
// the output is free, over its single registered read port. An install or
// an advertisement is one search sweep, then at most one write; after a
// last_entry advertisement a dump follows if the batch changed the table.
// A tick sweeps, ages and writes back valid nonzero-cost slots, then dumps.
// One item is in work at a time; in_ready is high only when idle.
//
// Reset clears all valid bits, the changed flag and the configuration
// registers to their defaults; the memory contents need no clearing.
// When the receiver stalls, the output register holds its entry and the
// dump sweep waits.
module distance_vector_route_table_unit #(
    parameter int TABLE_DEPTH = dvrt_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [dvrt_pkg::ADDR_W-1:0]         dest_addr,
    input  logic [dvrt_pkg::ADDR_W-1:0]         sender_addr,
    input  logic [dvrt_pkg::COST_W-1:0]         adv_cost,
    input  logic                                last_entry,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dvrt_pkg::ADDR_W-1:0]         out_addr,
    output logic [dvrt_pkg::COST_W-1:0]         out_cost,
    output logic                                out_last,
    input  logic                                cfg_we,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dvrt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] hop;
        logic [TTL_W-1:0]  ttl;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_APPLY, S_TICK, S_DUMP, S_DRAIN
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    state_t state_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic changed_reg;
    logic [COST_W-1:0] ttl_reload_reg, inf_reg, period_reg;
    logic [1:0] func_reg;
    logic [ADDR_W-1:0] dest_reg, sender_reg;
    logic [COST_W-1:0] cost_reg;
    logic last_reg;
    logic [CW-1:0] cnt_reg;     // read address issued
    logic          pend_reg;    // read data valid this cycle
    logic [IW-1:0] pidx_reg;    // slot of pending read
    logic d_hit_reg, s_hit_reg, free_hit_reg;
    logic [IW-1:0] d_idx_reg, free_idx_reg;
    logic [COST_W-1:0] d_cost_reg, s_cost_reg;
    logic [NW-1:0] n_reg;
    logic out_valid_reg, out_last_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [COST_W-1:0] out_cost_reg;

    // remaining valid slots after index, for out_last
    logic [TABLE_DEPTH-1:0] later_mask;
    logic any_later;
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            later_mask[i] = (i > int'(pidx_reg)) && valid_reg[i];
        end
        any_later = |later_mask;
    end

    logic [COST_W:0] sum;
    logic [COST_W-1:0] sat;
    assign sum = {1'b0, cost_reg} + {1'b0, s_cost_reg};
    assign sat = (sum > {1'b0, inf_reg}) ? inf_reg : sum[COST_W-1:0];

    logic [TTL_W-1:0] aged;
    assign aged = (rd_data_reg.ttl > period_reg) ? rd_data_reg.ttl - period_reg : '0;

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    logic rd_done;
    assign rd_done = (cnt_reg == CW'(TABLE_DEPTH));
    logic out_load;
    assign out_load = (state_reg == S_DUMP) && pend_reg && out_free
                      && valid_reg[pidx_reg] && (n_reg != NW'(MAX_RESULTS));

    always_comb
    begin
        rd_addr = cnt_reg[IW-1:0];
        if (state_reg == S_DUMP && pend_reg && !out_free)
        begin
            rd_addr = pidx_reg;
        end
        wr_en   = 1'b0;
        wr_addr = pidx_reg;
        wr_data = rd_data_reg;
        if (state_reg == S_APPLY)
        begin
            wr_en = 1'b1;
            wr_addr = d_idx_reg;
            wr_data.dest = dest_reg;
            wr_data.hop = sender_reg;
            wr_data.ttl = ttl_reload_reg;
            wr_data.cost = (func_reg == FUNC_INSTALL) ? cost_reg : sat;
            if (func_reg == FUNC_INSTALL && !d_hit_reg)
            begin
                wr_addr = free_idx_reg;
            end
            if (func_reg == FUNC_INSTALL && !d_hit_reg && !free_hit_reg)
            begin
                wr_en = 1'b0;
            end
            if (func_reg == FUNC_ADV && !(d_hit_reg && s_hit_reg && sat < d_cost_reg))
            begin
                wr_en = 1'b0;
            end
        end
        else if (state_reg == S_TICK && pend_reg && valid_reg[pidx_reg]
                 && rd_data_reg.cost != '0)
        begin
            wr_en = 1'b1;
            wr_data.ttl = aged;
            if (aged == '0)
            begin
                wr_data.cost = inf_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            changed_reg <= 1'b0;
            ttl_reload_reg <= 16'd90;
            inf_reg <= 16'd65535;
            period_reg <= 16'd30;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TTL_RELOAD: ttl_reload_reg <= cfg_data;
                    CFG_INFINITY:   inf_reg <= cfg_data;
                    CFG_TICK:       period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg <= func;
                        dest_reg <= dest_addr;
                        sender_reg <= sender_addr;
                        cost_reg <= adv_cost;
                        last_reg <= last_entry;
                        cnt_reg <= '0;
                        pend_reg <= 1'b0;
                        d_hit_reg <= 1'b0;
                        s_hit_reg <= 1'b0;
                        free_hit_reg <= 1'b0;
                        n_reg <= '0;
                        if (func == FUNC_TICK)
                        begin
                            state_reg <= S_TICK;
                        end
                        else if (func == FUNC_ADV || func == FUNC_INSTALL)
                        begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (!rd_done)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    pend_reg <= !rd_done;
                    pidx_reg <= cnt_reg[IW-1:0];
                    if (pend_reg)
                    begin
                        if (valid_reg[pidx_reg] && rd_data_reg.dest == dest_reg
                            && !d_hit_reg)
                        begin
                            d_hit_reg <= 1'b1;
                            d_idx_reg <= pidx_reg;
                            d_cost_reg <= rd_data_reg.cost;
                        end
                        if (valid_reg[pidx_reg] && rd_data_reg.dest == sender_reg
                            && !s_hit_reg)
                        begin
                            s_hit_reg <= 1'b1;
                            s_cost_reg <= rd_data_reg.cost;
                        end
                        if (!valid_reg[pidx_reg] && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_idx_reg <= pidx_reg;
                        end
                    end
                    if (rd_done && !pend_reg)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    cnt_reg <= '0;
                    pend_reg <= 1'b0;
                    if (func_reg == FUNC_INSTALL)
                    begin
                        if (wr_en)
                        begin
                            valid_reg[wr_addr] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (last_reg)
                    begin
                        changed_reg <= 1'b0;
                        state_reg <= (changed_reg || wr_en) ? S_DUMP : S_IDLE;
                    end
                    else
                    begin
                        if (wr_en)
                        begin
                            changed_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_TICK:
                begin
                    if (!rd_done)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    pend_reg <= !rd_done;
                    pidx_reg <= cnt_reg[IW-1:0];
                    if (rd_done && !pend_reg)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_DUMP;
                    end
                end
                S_DUMP:
                begin
                    if (out_free || !pend_reg)
                    begin
                        if (!rd_done)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        pend_reg <= !rd_done;
                        pidx_reg <= cnt_reg[IW-1:0];
                        if (out_load)
                        begin
                            out_valid_reg <= 1'b1;
                            out_addr_reg <= rd_data_reg.dest;
                            out_cost_reg <= rd_data_reg.cost;
                            out_last_reg <= !any_later
                                || (n_reg == NW'(MAX_RESULTS - 1));
                            n_reg <= n_reg + 1'b1;
                        end
                        if (rd_done && !pend_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_cost  = out_cost_reg;
    assign out_last  = out_last_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || state_reg == S_IDLE)
        else $error("ready outside idle");
    a_no_out_search: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !out_valid)
        else $error("output during search");
    a_install_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && func_reg == FUNC_INSTALL)
        |=> $stable(changed_reg))
        else $error("install touched changed flag");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_addr))
        else $error("output lost under stall");
endmodule
